[sv/dmm_packet_decoder_unit_assert.svh]
// ----------------------------------------------------------------------------
// dmm_packet_decoder_unit assertion macros
// Clocked property checks, reset-qualified or always on, used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef DMM_PACKET_DECODER_UNIT_ASSERT_SVH
`define DMM_PACKET_DECODER_UNIT_ASSERT_SVH

// Property checked on every rising clk edge outside reset.
`define DMM_PD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a property that must hold even while reset is applied.
`define DMM_PD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dmm_pd_pkg.sv]
// ----------------------------------------------------------------------------
// dmm_pd_pkg
// Types, byte codes and range tables for the meter packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pd_pkg;

  // Byte positions within a 14-byte packet
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_RANGE     = 4'd0;
  localparam logic [POS_W-1:0] POS_DIGIT_LO  = 4'd1;
  localparam logic [POS_W-1:0] POS_DIGIT_HI  = 4'd5;
  localparam logic [POS_W-1:0] POS_FUNCTION  = 4'd6;
  localparam logic [POS_W-1:0] POS_OPTION_LO = 4'd7;
  localparam logic [POS_W-1:0] POS_OPTION_HI = 4'd11;
  localparam logic [POS_W-1:0] POS_CR        = 4'd12;
  localparam logic [POS_W-1:0] POS_LF        = 4'd13;
  localparam logic [POS_W-1:0] POS_IDLE      = 4'd14;

  localparam int unsigned NUM_OPTIONS = 5;
  localparam int unsigned ACC_W       = 17;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;

  // Function byte codes
  localparam logic [7:0] FN_VOLT     = 8'h3B;
  localparam logic [7:0] FN_MICROAMP = 8'h3D;
  localparam logic [7:0] FN_MILLIAMP = 8'h3F;
  localparam logic [7:0] FN_AMP_22   = 8'h30;
  localparam logic [7:0] FN_AMP_MAN  = 8'h39;
  localparam logic [7:0] FN_OHM      = 8'h33;
  localparam logic [7:0] FN_CONT     = 8'h35;
  localparam logic [7:0] FN_DIODE    = 8'h31;
  localparam logic [7:0] FN_FREQ     = 8'h32;
  localparam logic [7:0] FN_CAP      = 8'h36;
  localparam logic [7:0] FN_TEMP     = 8'h34;

  // Quantity codes
  localparam logic [3:0] QTY_NONE  = 4'd0;
  localparam logic [3:0] QTY_VOLT  = 4'd1;
  localparam logic [3:0] QTY_AMP   = 4'd2;
  localparam logic [3:0] QTY_OHM   = 4'd3;
  localparam logic [3:0] QTY_HERTZ = 4'd4;
  localparam logic [3:0] QTY_FARAD = 4'd5;
  localparam logic [3:0] QTY_DEGC  = 4'd6;
  localparam logic [3:0] QTY_DEGF  = 4'd7;
  localparam logic [3:0] QTY_CONT  = 4'd8;
  localparam logic [3:0] QTY_DIODE = 4'd9;
  localparam logic [3:0] QTY_DUTY  = 4'd10;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE = 3'd2;
  localparam logic [2:0] ST_NO_SCALE  = 3'd3;
  localparam logic [2:0] ST_ZERO_FACT = 3'd4;

  // Power-of-ten exponent per table row and range index
  localparam logic signed [4:0] EXP_TABLE [8][8] = '{
    '{-5'sd4,  -5'sd3,  -5'sd2,  -5'sd1, -5'sd5,  5'sd0,  5'sd0,  5'sd0},
    '{-5'sd8,  -5'sd7,   5'sd0,   5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{-5'sd6,  -5'sd5,   5'sd0,   5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{-5'sd3,   5'sd0,   5'sd0,   5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{-5'sd4,  -5'sd3,  -5'sd2,  -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{-5'sd2,  -5'sd1,   5'sd0,   5'sd1,  5'sd2,  5'sd3,  5'sd4,  5'sd0},
    '{-5'sd2,  -5'sd1,   5'sd0,   5'sd0,  5'sd1,  5'sd2,  5'sd3,  5'sd4},
    '{-5'sd12, -5'sd11, -5'sd10, -5'sd9, -5'sd8, -5'sd7, -5'sd6, -5'sd5}
  };
  localparam logic [7:0] EXP_VALID [8] = '{
    8'h1F, 8'h03, 8'h03, 8'h01, 8'h1F, 8'h7F, 8'hFB, 8'hFF
  };

  // Over-limit digits "22580"
  function automatic logic [7:0] limit_digit(input logic [POS_W-1:0] pos);
    logic [7:0] d;
    unique case (pos)
      4'd1, 4'd2: d = 8'h32;
      4'd3:       d = 8'h35;
      4'd4:       d = 8'h38;
      default:    d = 8'h30;
    endcase
    return d;
  endfunction

  // Running packet fields
  typedef struct packed {
    logic [7:0]                       range_byte;
    logic [ACC_W-1:0]                 digit_acc;
    logic                             digits_valid;
    logic                             limit_match;
    logic [7:0]                       function_byte;
    logic [NUM_OPTIONS-1:0][3:0]      option_nib;
    logic                             cr_seen;
  } pkt_state_t;

  // Result item, mantissa in the low bits
  typedef struct packed {
    logic [7:0]         indicator_flags;
    logic [6:0]         measure_flags;
    logic               packet_ok;
    logic               over_limit;
    logic [2:0]         status;
    logic [3:0]         quantity;
    logic signed [4:0]  exponent;
    logic signed [17:0] mantissa;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[sv/dmm_pd_decode.sv]
// ----------------------------------------------------------------------------
// dmm_pd_decode
// Turns the collected packet fields and the final byte into one result.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_pd_decode (
  input  wire dmm_pd_pkg::pkt_state_t st,
  input  wire logic [7:0]             last_byte,
  output dmm_pd_pkg::result_t         res
);

  logic       judge, sign, ac, dc;
  logic       has_row;
  logic [2:0] row;
  logic [3:0] quantity;
  logic       cont, neg;
  logic [7:0] idx;
  logic [2:0] status;
  logic signed [17:0] mant;
  logic signed [4:0]  expo;

  assign judge = st.option_nib[0][3];
  assign sign  = st.option_nib[0][2];
  assign dc    = st.option_nib[3][3];
  assign ac    = st.option_nib[3][2];

  always_comb begin
    quantity = dmm_pd_pkg::QTY_NONE;
    has_row  = 1'b0;
    row      = 3'd0;
    unique case (st.function_byte)
      dmm_pd_pkg::FN_VOLT: begin
        quantity = dmm_pd_pkg::QTY_VOLT; has_row = 1'b1; row = 3'd0;
      end
      dmm_pd_pkg::FN_MICROAMP: begin
        quantity = dmm_pd_pkg::QTY_AMP; has_row = 1'b1; row = 3'd1;
      end
      dmm_pd_pkg::FN_MILLIAMP: begin
        quantity = dmm_pd_pkg::QTY_AMP; has_row = 1'b1; row = 3'd2;
      end
      dmm_pd_pkg::FN_AMP_22: begin
        quantity = dmm_pd_pkg::QTY_AMP; has_row = 1'b1; row = 3'd3;
      end
      dmm_pd_pkg::FN_AMP_MAN: begin
        quantity = dmm_pd_pkg::QTY_AMP; has_row = 1'b1; row = 3'd4;
      end
      dmm_pd_pkg::FN_OHM: begin
        quantity = dmm_pd_pkg::QTY_OHM; has_row = 1'b1; row = 3'd5;
      end
      dmm_pd_pkg::FN_CONT:  quantity = dmm_pd_pkg::QTY_CONT;
      dmm_pd_pkg::FN_DIODE: quantity = dmm_pd_pkg::QTY_DIODE;
      dmm_pd_pkg::FN_FREQ: begin
        // judge bit picks frequency over duty cycle
        quantity = judge ? dmm_pd_pkg::QTY_HERTZ : dmm_pd_pkg::QTY_DUTY;
        has_row  = judge;
        row      = 3'd6;
      end
      dmm_pd_pkg::FN_CAP: begin
        quantity = dmm_pd_pkg::QTY_FARAD; has_row = 1'b1; row = 3'd7;
      end
      dmm_pd_pkg::FN_TEMP:
        quantity = judge ? dmm_pd_pkg::QTY_DEGC : dmm_pd_pkg::QTY_DEGF;
      default: quantity = dmm_pd_pkg::QTY_NONE;
    endcase
  end

  assign cont = (quantity == dmm_pd_pkg::QTY_CONT);
  assign neg  = sign && (st.digit_acc != '0);
  assign idx  = st.range_byte - dmm_pd_pkg::ASCII_ZERO;

  always_comb begin
    status = dmm_pd_pkg::ST_OK;
    mant   = '0;
    expo   = '0;
    priority if (st.limit_match) begin
      mant = cont ? 18'sd1 : 18'sd0;
    end else if (!st.digits_valid) begin
      status = dmm_pd_pkg::ST_BAD_DIGIT;
    end else if (cont) begin
      mant = neg ? 18'sd0 : 18'sd1;
    end else if (neg) begin
      mant = -$signed({1'b0, st.digit_acc});
    end else begin
      mant = $signed({1'b0, st.digit_acc});
    end

    if (status == dmm_pd_pkg::ST_OK) begin
      priority if (idx > 8'd7) begin
        status = dmm_pd_pkg::ST_BAD_RANGE;
      end else if (!has_row) begin
        status = dmm_pd_pkg::ST_NO_SCALE;
      end else if (!dmm_pd_pkg::EXP_VALID[row][idx[2:0]]) begin
        status = dmm_pd_pkg::ST_ZERO_FACT;
      end else begin
        expo = dmm_pd_pkg::EXP_TABLE[row][idx[2:0]];
      end
    end
  end

  always_comb begin
    res.mantissa   = mant;
    res.exponent   = expo;
    res.quantity   = quantity;
    res.status     = status;
    res.over_limit = st.limit_match;
    res.packet_ok  = st.cr_seen && (last_byte == dmm_pd_pkg::ASCII_LF) && !(ac && dc);
    res.measure_flags = {st.option_nib[1][1], st.option_nib[1][2], st.option_nib[1][3],
                         st.option_nib[4][1], st.option_nib[3][1], dc, ac};
    res.indicator_flags = {st.option_nib[4][0], st.option_nib[4][2], st.option_nib[3][0],
                           st.option_nib[2][1], st.option_nib[2][2], st.option_nib[0][0],
                           st.option_nib[0][1], judge};
  end

endmodule

`default_nettype wire

[sv/dmm_packet_decoder_unit.sv]
// ----------------------------------------------------------------------------
// dmm_packet_decoder_unit
// Decoder for the 14-byte serial packet of a digital multimeter.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one packet byte per request in in_tdata; in_tuser high marks
//   the range byte (byte 0) and restarts decoding even mid-packet. After reset
//   an unmarked byte is also taken as byte 0. Bytes after byte 13 are dropped
//   until the next marked byte.
//   Result stream: one request per packet, built from the running fields and
//   byte 13 and registered (in the second result register if the first waits).
//   Throughput: one byte per cycle while in_tready is high; each byte updates
//   the registered running fields, and the decode of byte 13 is one level of
//   logic ahead of the result register.
//   Stall: a second result register catches a result while the first waits;
//   in_tready drops only when both hold results.
//   Reset (rst_n low, synchronous): both result registers empty, packet
//   position at byte 0, running fields at their start values.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_packet_decoder_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [7:0]                           in_tdata,   // [7:0] data_byte
  input  wire logic                                 in_tuser,   // [0] packet_start
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [17:0] mantissa, [22:18] exponent, [26:23] quantity, [29:27] status,
  // [30] over_limit, [31] packet_ok, [38:32] measure_flags,
  // [46:39] indicator_flags, [47] zero
  output logic [dmm_pd_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  `include "dmm_packet_decoder_unit_assert.svh"

  localparam int unsigned PAD_W = dmm_pd_pkg::OUT_TDATA_W - dmm_pd_pkg::RESULT_W;
  localparam int unsigned ACC_MUL_W = dmm_pd_pkg::ACC_W + 4;

  logic [dmm_pd_pkg::POS_W-1:0] pos_r, pos_nxt, pos_cur;
  dmm_pd_pkg::pkt_state_t       st_r, st_nxt;
  dmm_pd_pkg::result_t          dec_res;
  dmm_pd_pkg::result_t          out_r, skid_r;
  logic                         out_v_r, skid_v_r;
  logic                         in_fire, push, pop;
  logic [ACC_MUL_W-1:0]         acc_mul;
  logic                         is_digit;

  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign pos_cur   = in_tuser ? dmm_pd_pkg::POS_RANGE : pos_r;
  assign push      = in_fire && (pos_cur == dmm_pd_pkg::POS_LF);
  assign pop       = out_v_r && out_tready;

  assign is_digit = (in_tdata >= dmm_pd_pkg::ASCII_ZERO) && (in_tdata <= dmm_pd_pkg::ASCII_NINE);
  // acc * 10 as (acc << 3) + (acc << 1), then the digit value
  assign acc_mul  = {1'b0, st_r.digit_acc, 3'b000} + {3'b000, st_r.digit_acc, 1'b0}
                    + {{(ACC_MUL_W-4){1'b0}}, in_tdata[3:0]};

  always_comb begin
    st_nxt  = st_r;
    pos_nxt = pos_r;
    if (in_fire && (pos_cur < dmm_pd_pkg::POS_IDLE)) begin
      pos_nxt = pos_cur + 4'd1;
      priority if (pos_cur == dmm_pd_pkg::POS_RANGE) begin
        st_nxt.range_byte   = in_tdata;
        st_nxt.digit_acc    = '0;
        st_nxt.digits_valid = 1'b1;
        st_nxt.limit_match  = 1'b1;
        st_nxt.cr_seen      = 1'b0;
      end else if (pos_cur <= dmm_pd_pkg::POS_DIGIT_HI) begin
        if (!is_digit) begin
          st_nxt.digits_valid = 1'b0;
        end else if (st_r.digits_valid) begin
          st_nxt.digit_acc = acc_mul[dmm_pd_pkg::ACC_W-1:0];
        end
        if (in_tdata != dmm_pd_pkg::limit_digit(pos_cur)) begin
          st_nxt.limit_match = 1'b0;
        end
      end else if (pos_cur == dmm_pd_pkg::POS_FUNCTION) begin
        st_nxt.function_byte = in_tdata;
      end else if (pos_cur <= dmm_pd_pkg::POS_OPTION_HI) begin
        st_nxt.option_nib[3'(pos_cur - dmm_pd_pkg::POS_OPTION_LO)] = in_tdata[3:0];
      end else if (pos_cur == dmm_pd_pkg::POS_CR) begin
        st_nxt.cr_seen = (in_tdata == dmm_pd_pkg::ASCII_CR);
      end else begin
        pos_nxt = dmm_pd_pkg::POS_IDLE;
      end
    end
  end

  dmm_pd_decode u_decode (
    .st        (st_r),
    .last_byte (in_tdata),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= dmm_pd_pkg::POS_RANGE;
      st_r     <= '{range_byte: 8'h00, digit_acc: '0, digits_valid: 1'b1,
                    limit_match: 1'b1, function_byte: 8'h00, option_nib: '0,
                    cr_seen: 1'b0};
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      st_r  <= st_nxt;
      if (pop || !out_v_r) begin
        if (skid_v_r) begin
          out_r    <= skid_r;
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_r   <= dec_res;
          out_v_r <= push;
        end
      end else if (push) begin
        skid_r   <= dec_res;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_r};

  `DMM_PD_ASSERT(a_skid_needs_out, skid_v_r |-> out_v_r, "skid holds a result while output empty")
  `DMM_PD_ASSERT(a_idle_after_lf, push |=> (pos_r == dmm_pd_pkg::POS_IDLE), "position not idle after last byte")
  `DMM_PD_ASSERT(a_no_scale_zero_exp, (out_v_r && (out_r.status != dmm_pd_pkg::ST_OK)) |-> (out_r.exponent == 5'sd0), "exponent set on failed scale")
  `DMM_PD_ASSERT(a_limit_not_bad_digit, (out_v_r && out_r.over_limit) |-> (out_r.status != dmm_pd_pkg::ST_BAD_DIGIT), "over-limit result flagged as bad digit")
  `DMM_PD_ASSERT(a_pos_range, (pos_r <= dmm_pd_pkg::POS_IDLE), "packet position beyond idle")

endmodule

`default_nettype wire

[bench/dmm_pd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_pd_checker
// Watches both streams of the packet decoder. Accepted bytes drive a local
// decoder that queues the reading each complete packet should give.
// Accepted results are compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module dmm_pd_checker
  import dmm_pd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] packet_start
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // result_t, zero padded
  output int                     fail_count,
  output int                     due_count
);

  // exponent per scale row and range index, with a mask of usable indexes
  localparam int SCALE_EXP [8][8] = '{
    '{ -4,  -3,  -2,  -1,  -5,   0,   0,   0},
    '{ -8,  -7,   0,   0,   0,   0,   0,   0},
    '{ -6,  -5,   0,   0,   0,   0,   0,   0},
    '{ -3,   0,   0,   0,   0,   0,   0,   0},
    '{ -4,  -3,  -2,  -1,   0,   0,   0,   0},
    '{ -2,  -1,   0,   1,   2,   3,   4,   0},
    '{ -2,  -1,   0,   0,   1,   2,   3,   4},
    '{-12, -11, -10,  -9,  -8,  -7,  -6,  -5}
  };
  localparam logic [7:0] SCALE_OK [8] = '{
    8'h1F, 8'h03, 8'h03, 8'h01, 8'h1F, 8'h7F, 8'hFB, 8'hFF
  };
  localparam logic [7:0] OVER_DIGITS [5] = '{8'h32, 8'h32, 8'h35, 8'h38, 8'h30};

  logic [3:0]  pos_q;
  logic [7:0]  range_q;
  logic [16:0] acc_q;
  bit          digits_ok_q;
  bit          over_q;
  logic [7:0]  func_q;
  logic [3:0]  opt_q [5];
  bit          cr_q;

  result_t readings_due [$];
  int      errs = 0;

  function automatic result_t decode_reading(input logic [7:0] last);
    result_t r;
    bit judge, sign, dc, ac, cont, neg;
    int row;
    logic [7:0] idx;
    judge = opt_q[0][3];
    sign  = opt_q[0][2];
    dc    = opt_q[3][3];
    ac    = opt_q[3][2];
    row   = -1;
    r     = '0;
    r.quantity = QTY_NONE;
    case (func_q)
      FN_VOLT:     begin r.quantity = QTY_VOLT; row = 0; end
      FN_MICROAMP: begin r.quantity = QTY_AMP;  row = 1; end
      FN_MILLIAMP: begin r.quantity = QTY_AMP;  row = 2; end
      FN_AMP_22:   begin r.quantity = QTY_AMP;  row = 3; end
      FN_AMP_MAN:  begin r.quantity = QTY_AMP;  row = 4; end
      FN_OHM:      begin r.quantity = QTY_OHM;  row = 5; end
      FN_CONT:     r.quantity = QTY_CONT;
      FN_DIODE:    r.quantity = QTY_DIODE;
      FN_FREQ: begin
        r.quantity = judge ? QTY_HERTZ : QTY_DUTY;
        row = judge ? 6 : -1;
      end
      FN_CAP:      begin r.quantity = QTY_FARAD; row = 7; end
      FN_TEMP:     r.quantity = judge ? QTY_DEGC : QTY_DEGF;
      default:     r.quantity = QTY_NONE;
    endcase
    cont = (r.quantity == QTY_CONT);
    r.status = ST_OK;

    if (over_q) begin
      r.mantissa = cont ? 18'sd1 : 18'sd0;
    end else if (!digits_ok_q) begin
      r.status = ST_BAD_DIGIT;
    end else begin
      neg = sign && (acc_q != 0);
      if (cont)
        r.mantissa = neg ? 18'sd0 : 18'sd1;
      else
        r.mantissa = neg ? (18'd0 - {1'b0, acc_q}) : {1'b0, acc_q};
    end

    if (r.status == ST_OK) begin
      idx = range_q - ASCII_ZERO;
      if (idx > 8'd7)
        r.status = ST_BAD_RANGE;
      else if (row < 0)
        r.status = ST_NO_SCALE;
      else if (!SCALE_OK[row][idx[2:0]])
        r.status = ST_ZERO_FACT;
      else
        r.exponent = 5'(SCALE_EXP[row][idx[2:0]]);
    end

    r.over_limit = over_q;
    r.packet_ok  = cr_q && (last == ASCII_LF) && !(ac && dc);
    r.measure_flags = {opt_q[1][1], opt_q[1][2], opt_q[1][3], opt_q[4][1],
                       opt_q[3][1], dc, ac};
    r.indicator_flags = {opt_q[4][0], opt_q[4][2], opt_q[3][0], opt_q[2][1],
                         opt_q[2][2], opt_q[0][0], opt_q[0][1], judge};
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [3:0] pos;
    pos = start ? 4'd0 : pos_q;
    if (pos >= 4'd14)
      return;
    if (pos == 4'd0) begin
      range_q     = b;
      acc_q       = '0;
      digits_ok_q = 1'b1;
      over_q      = 1'b1;
      cr_q        = 1'b0;
    end else if (pos <= 4'd5) begin
      if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
        if (digits_ok_q)
          acc_q = 17'(acc_q * 10 + (b - ASCII_ZERO));
      end else begin
        digits_ok_q = 1'b0;
      end
      if (b != OVER_DIGITS[pos - 1])
        over_q = 1'b0;
    end else if (pos == 4'd6) begin
      func_q = b;
    end else if (pos <= 4'd11) begin
      opt_q[pos - 7] = b[3:0];
    end else if (pos == 4'd12) begin
      cr_q = (b == ASCII_CR);
    end else begin
      pos_q = 4'd14;
      readings_due.push_back(decode_reading(b));
      return;
    end
    pos_q = pos + 4'd1;
  endtask

  task automatic check_reading(input logic [OUT_TDATA_W-1:0] raw);
    result_t got, want;
    got = result_t'(raw[RESULT_W-1:0]);
    if (readings_due.size() == 0) begin
      $error("unexpected result request, tdata %h", raw);
      errs++;
      return;
    end
    want = readings_due.pop_front();
    if (got.mantissa !== want.mantissa) begin
      $error("mantissa expected %0d got %0d", want.mantissa, got.mantissa);
      errs++;
    end
    if (got.exponent !== want.exponent) begin
      $error("exponent expected %0d got %0d", want.exponent, got.exponent);
      errs++;
    end
    if (got.quantity !== want.quantity) begin
      $error("quantity expected %0d got %0d", want.quantity, got.quantity);
      errs++;
    end
    if (got.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, got.status);
      errs++;
    end
    if (got.over_limit !== want.over_limit) begin
      $error("over_limit expected %0d got %0d", want.over_limit, got.over_limit);
      errs++;
    end
    if (got.packet_ok !== want.packet_ok) begin
      $error("packet_ok expected %0d got %0d", want.packet_ok, got.packet_ok);
      errs++;
    end
    if (got.measure_flags !== want.measure_flags) begin
      $error("measure_flags expected %h got %h", want.measure_flags, got.measure_flags);
      errs++;
    end
    if (got.indicator_flags !== want.indicator_flags) begin
      $error("indicator_flags expected %h got %h", want.indicator_flags,
             got.indicator_flags);
      errs++;
    end
    if (raw[OUT_TDATA_W-1:RESULT_W] !== '0) begin
      $error("padding expected 0 got %h", raw[OUT_TDATA_W-1:RESULT_W]);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pos_q       = 4'd0;
      range_q     = '0;
      acc_q       = '0;
      digits_ok_q = 1'b1;
      over_q      = 1'b1;
      func_q      = '0;
      for (int i = 0; i < 5; i++)
        opt_q[i] = '0;
      cr_q = 1'b0;
      readings_due.delete();
    end else begin
      // a result taken at this edge always comes from an earlier byte
      if (out_tvalid && out_tready)
        check_reading(out_tdata);
      if (in_tvalid && in_tready)
        decode_byte(in_tdata, in_tuser);
    end
    due_count  <= readings_due.size();
    fail_count <= errs;
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the meter packet decoder: a few hand-built packets, then
// weighted random packets under three sender/receiver stall mixes and one
// long receiver hold-off. Checking is done by dmm_pd_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import dmm_pd_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] FN_CODES [11] = '{
    FN_VOLT, FN_MICROAMP, FN_MILLIAMP, FN_AMP_22, FN_AMP_MAN, FN_OHM,
    FN_CONT, FN_DIODE, FN_FREQ, FN_CAP, FN_TEMP
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int due_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  bit hold_req = 1'b0;

  dmm_packet_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dmm_pd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // sends the first count bytes of a packet
  task automatic send_packet(input logic [7:0] rng, input logic [39:0] digits,
                             input logic [7:0] func, input logic [39:0] opts,
                             input logic [7:0] cr, input logic [7:0] lf,
                             input logic mark, input int count);
    logic [7:0] pkt [14];
    pkt[0] = rng;
    for (int i = 0; i < 5; i++) begin
      pkt[1 + i] = digits[39 - 8*i -: 8];
      pkt[7 + i] = opts[39 - 8*i -: 8];
    end
    pkt[6]  = func;
    pkt[12] = cr;
    pkt[13] = lf;
    for (int i = 0; i < count; i++) begin
      send_byte(pkt[i], (i == 0) ? mark : 1'b0);
      bytes_sent++;
    end
  endtask

  task automatic send_random_packet();
    logic [7:0]  rng, func, cr, lf;
    logic [39:0] digits, opts;
    int kind, dsel, count;
    kind = $urandom_range(99);
    rng  = ($urandom_range(9) != 0) ? 8'(ASCII_ZERO + $urandom_range(7))
                                    : 8'($urandom_range(255));
    dsel = $urandom_range(99);
    for (int i = 0; i < 5; i++)
      digits[39 - 8*i -: 8] = 8'(ASCII_ZERO + $urandom_range(9));
    if (dsel < 10)
      digits = "22580";
    else if (dsel < 16)
      digits = "00000";
    else if (dsel < 20)
      digits = "99999";
    else if (dsel < 24)
      digits = "22581";
    else if (dsel < 32)
      digits[8*$urandom_range(4) +: 8] = 8'($urandom_range(255));
    else if (dsel < 36)
      digits = {$urandom, 8'($urandom_range(255))};
    func = ($urandom_range(99) < 88) ? FN_CODES[$urandom_range(10)]
                                     : 8'($urandom_range(255));
    opts = {$urandom, 8'($urandom_range(255))};
    cr = ($urandom_range(9) != 0) ? ASCII_CR : 8'($urandom_range(255));
    lf = ($urandom_range(9) != 0) ? ASCII_LF : 8'($urandom_range(255));
    // cut packets are restarted by the next marked byte
    count = (kind < 7) ? $urandom_range(1, 13) : 14;
    send_packet(rng, digits, func, opts, cr, lf, 1'b1, count);
    // trailing unmarked bytes: ignored after a full packet
    if (kind >= 7 && kind < 12)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input bit hold,
                           input int target);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    if (hold)
      hold_req = 1'b1;
    while (bytes_sent < target)
      send_random_packet();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 32;
    recv_idle_pct = 83;

    // first packet unmarked after reset: over limit, continuity, sign set,
    // AC and DC both on
    send_packet(8'h37, "22580", FN_CONT, {8'h04, 8'h00, 8'h00, 8'h0C, 8'h00},
                ASCII_CR, ASCII_LF, 1'b0, 14);
    // ignored while idle
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // cut short, restarted by the first random packet
    send_packet(ASCII_ZERO, "12345", FN_VOLT, 40'h0, ASCII_CR, ASCII_LF, 1'b1, 5);

    run_phase(32, 83, 1'b0, 700);
    run_phase(83, 32, 1'b0, 1400);
    run_phase(0, 0, 1'b1, 2100);
    in_tvalid <= 1'b0;

    while (due_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
